FILE: hw/rtl/spq_pkg.sv
// Shared constants and types of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int KIND_W = 2;
  localparam int PRIO_W = 8;
  localparam int DATA_W = 32;
  localparam int MINP_W = 9;
  localparam int LEN_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [MINP_W-1:0] MINP_EMPTY = 9'h1FF;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // perform the operation and load the result register
  } spq_cmd_t;

endpackage

FILE: hw/rtl/spq_ctrl.sv
// Controller of the sorted priority queue: item sequencing and result handshake.
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output spq_pkg::spq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // no item is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;
  assign cmd.load = in_ready && in_valid;
  // result register free, or being emptied this cycle
  assign cmd.exec = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_ready) out_valid <= 1'b0;
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.exec) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/spq_datapath.sv
// Datapath of the sorted priority queue: sorted entry row, insert/shift logic, result register.
`timescale 1ns / 1ps
module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spq_pkg::spq_cmd_t                 cmd,
  input  logic [spq_pkg::KIND_W-1:0]        kind,
  input  logic [spq_pkg::PRIO_W-1:0]        item_priority,
  input  logic [spq_pkg::DATA_W-1:0]        item_data,
  output logic [spq_pkg::DATA_W-1:0]        out_data,
  output logic                              out_data_valid,
  output logic signed [spq_pkg::MINP_W-1:0] min_priority,
  output logic [spq_pkg::LEN_W-1:0]         queue_length,
  output logic [spq_pkg::STAT_W-1:0]        status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // captured item
  logic [spq_pkg::KIND_W-1:0] op_kind;
  logic [spq_pkg::PRIO_W-1:0] op_prio;
  logic [spq_pkg::DATA_W-1:0] op_data;

  // sorted entries, head at index 0
  logic [spq_pkg::PRIO_W-1:0] prio_q [DEPTH];
  logic [spq_pkg::DATA_W-1:0] data_q [DEPTH];
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;

  logic [DEPTH-1:0] gt;      // stored entry outranked by the new one
  logic [DEPTH-1:0] ins_at;  // new entry lands here
  logic [DEPTH-1:0] shift_up;

  logic is_full, is_empty, do_enq, do_deq;

  logic [spq_pkg::DATA_W-1:0] res_data;
  logic                       res_dvalid;
  logic [spq_pkg::PRIO_W-1:0] head_prio;
  logic                       head_valid;
  logic [spq_pkg::STAT_W-1:0] res_status;
  logic [CW+spq_pkg::LEN_W-1:0] len_wide;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= kind;
      op_prio <= item_priority;
      op_data <= item_data;
    end
  end

  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);
  assign do_enq   = (op_kind == spq_pkg::KIND_ENQ) && !is_full;
  assign do_deq   = (op_kind == spq_pkg::KIND_DEQ) && !is_empty;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CW'(i) < count) && (prio_q[i] > op_prio);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        shift_up[i] = 1'b0;
        ins_at[i]   = gt[i] || (count == '0);
      end else begin
        shift_up[i] = gt[i-1];
        ins_at[i]   = !gt[i-1] && (gt[i] || (count == CW'(i)));
      end
    end
  end

  // one cell per entry: hold, take the neighbor below/above, or take the new item
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_enq) begin
          if (ins_at[g]) begin
            prio_q[g] <= op_prio;
            data_q[g] <= op_data;
          end else if (shift_up[g]) begin
            prio_q[g] <= prio_q[(g == 0) ? 0 : g - 1];
            data_q[g] <= data_q[(g == 0) ? 0 : g - 1];
          end
        end else if (do_deq && (g < DEPTH - 1)) begin
          prio_q[g] <= prio_q[(g < DEPTH - 1) ? g + 1 : g];
          data_q[g] <= data_q[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_enq) count_next = count + CW'(1);
    else if (do_deq) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // result of the step, from the pre-update row
  always_comb begin
    res_status = spq_pkg::ST_DONE;
    res_data   = '0;
    res_dvalid = 1'b0;
    head_prio  = prio_q[0];
    head_valid = !is_empty;
    case (op_kind)
      spq_pkg::KIND_ENQ: begin
        if (is_full) begin
          res_status = spq_pkg::ST_FULL;
          res_data   = data_q[0];
          res_dvalid = 1'b1;
        end else begin
          res_dvalid = 1'b1;
          head_valid = 1'b1;
          if (ins_at[0]) begin
            res_data  = op_data;
            head_prio = op_prio;
          end else begin
            res_data  = data_q[0];
          end
        end
      end
      spq_pkg::KIND_DEQ: begin
        if (is_empty) begin
          res_status = spq_pkg::ST_EMPTY;
        end else begin
          res_data   = data_q[0];
          res_dvalid = 1'b1;
          head_prio  = prio_q[1];
          head_valid = (count_next != '0);
        end
      end
      default: begin
        if (!is_empty) begin
          res_data   = data_q[0];
          res_dvalid = 1'b1;
        end
      end
    endcase
  end

  assign len_wide = {{spq_pkg::LEN_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data       <= res_data;
      out_data_valid <= res_dvalid;
      min_priority   <= head_valid ? {1'b0, head_prio} : spq_pkg::MINP_EMPTY;
      queue_length   <= len_wide[spq_pkg::LEN_W-1:0];
      status         <= res_status;
    end
  end

endmodule

FILE: hw/rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller plus datapath.
`timescale 1ns / 1ps
// Sorted priority queue of up to DEPTH entries (priority, data), lowest
// priority value at the head, equal priorities served first in, first out.
// Input channel (in_valid/in_ready) carries one item: kind 0 enqueue,
// 1 dequeue, 2 or 3 query. Output channel (out_valid/out_ready) returns one
// result item per input item: dequeued or head data, its valid flag, head
// priority after the step (-1 when empty), length and status.
// An accepted item is first captured, then executed into the output register
// once that register is free. A new item is taken only after the previous one
// has executed, following the capture then execute sequence of the controller;
// the insert compare and the shift of the whole entry row happen together in
// the execute cycle.
// The output register parts the two sides: a new item is accepted while a
// result still waits. If the receiver stalls, the next item waits in execute
// until the result register empties, and in_ready stays low meanwhile.
// Reset (rst, synchronous) empties the queue, drops out_valid and holds
// in_ready low while asserted; entry contents are not cleared, only the length.
module sorted_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spq_pkg::KIND_W-1:0]        kind,
  input  logic [spq_pkg::PRIO_W-1:0]        item_priority,
  input  logic [spq_pkg::DATA_W-1:0]        item_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::DATA_W-1:0]        out_data,
  output logic                              out_data_valid,
  output logic signed [spq_pkg::MINP_W-1:0] min_priority,
  output logic [spq_pkg::LEN_W-1:0]         queue_length,
  output logic [spq_pkg::STAT_W-1:0]        status
);

  spq_pkg::spq_cmd_t cmd;

  // sequencing and handshake
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // entry row and result register
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .kind           (kind),
    .item_priority  (item_priority),
    .item_data      (item_data),
    .out_data       (out_data),
    .out_data_valid (out_data_valid),
    .min_priority   (min_priority),
    .queue_length   (queue_length),
    .status         (status)
  );

endmodule

FILE: hw/rtl/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
module spq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [spq_pkg::DATA_W-1:0]        out_data,
  input logic                              out_data_valid,
  input logic signed [spq_pkg::MINP_W-1:0] min_priority,
  input logic [spq_pkg::LEN_W-1:0]         queue_length,
  input logic [spq_pkg::STAT_W-1:0]        status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(status))
    else $error("result changed while stalled");

  // no data shown without an entry behind it
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data_valid |-> out_data == '0)
    else $error("out_data nonzero without valid entry");

  // empty dequeue reports an empty queue
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_EMPTY |->
      !out_data_valid && queue_length == '0 && min_priority == spq_pkg::MINP_EMPTY)
    else $error("empty dequeue with nonempty report");

  // rejected enqueue still shows the head
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_FULL |->
      out_data_valid && min_priority != spq_pkg::MINP_EMPTY)
    else $error("full reject without head");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_data       (out_data),
  .out_data_valid (out_data_valid),
  .min_priority   (min_priority),
  .queue_length   (queue_length),
  .status         (status)
);
